// ----- hdl/assert_macros.svh -----
// Assertion macros used by the top level of the row predicate filter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on clk outside reset.
`define TRPF_ASSERT_NOW(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, checked on clk outside reset.
`define TRPF_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed: next-cycle implication");

`endif

// ----- hdl/trpf_pkg.sv -----
// Package for the row predicate filter: codes, widths and controller/datapath structs.
`timescale 1ns / 1ps

package trpf_pkg;

  // Field widths
  localparam int ROW_W   = 10;
  localparam int VAL_W   = 48;
  localparam int COND_W  = 3;
  localparam int CONN_W  = 2;
  localparam int BLOCK_W = 4;
  localparam int OP_W    = 2;
  localparam int BIT_W   = 6;                 // bit position within a 64-row word
  localparam int WORD_BITS = 64;
  localparam int MAX_WORDS = 2 ** BLOCK_W;    // words the row field can reach

  // Stream widths, padded to whole bytes
  localparam int IN_TDATA_W  = 120;
  localparam int OUT_TDATA_W = 16;
  localparam int CFG_TDATA_W = 48;

  localparam int ROW_COUNT_DEF = 1024;

  // Sentinel value after reset: most negative 48-bit number
  localparam logic [VAL_W-1:0] UNDEF_RESET = {1'b1, {(VAL_W-1){1'b0}}};

  typedef enum logic [OP_W-1:0] {
    OP_EVAL   = 2'd0,
    OP_REPORT = 2'd1,
    OP_CLEAR  = 2'd2
  } op_t;

  typedef enum logic [COND_W-1:0] {
    COND_EQ  = 3'd0,
    COND_NEQ = 3'd1,
    COND_LT  = 3'd2,
    COND_LE  = 3'd3,
    COND_GE  = 3'd4,
    COND_GT  = 3'd5
  } cond_t;

  typedef enum logic [CONN_W-1:0] {
    CONN_NONE = 2'd0,
    CONN_OR   = 2'd1,
    CONN_AND  = 2'd2
  } conn_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic capture;     // latch the request fields
    logic load_scan;   // load report word for the requested block
    logic clear_all;   // zero every match bit
    logic eval;        // read-modify-write of one match bit
    logic emit;        // push next report result into the output register
  } dp_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic out_free;    // output register can take a result this cycle
    logic scan_last;   // result being picked is the final one of the report
  } dp_status_t;

endpackage

// ----- hdl/trpf_ctrl.sv -----
// Controller state machine of the row predicate filter.
`timescale 1ns / 1ps

module trpf_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic [trpf_pkg::OP_W-1:0]   in_op,
  input  trpf_pkg::dp_status_t        status,
  output logic                        in_ready,
  output trpf_pkg::dp_cmd_t           cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_REPORT
  } state_t;

  state_t state_r;
  logic   accept;

  // Requests are taken only when idle
  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;

  // Command decode
  always_comb begin
    cmd           = '0;
    cmd.capture   = accept;
    cmd.load_scan = accept && (in_op == trpf_pkg::OP_REPORT);
    cmd.clear_all = accept && (in_op == trpf_pkg::OP_CLEAR);
    cmd.eval      = (state_r == ST_EVAL);
    cmd.emit      = (state_r == ST_REPORT) && status.out_free;
  end

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (accept && (in_op == trpf_pkg::OP_EVAL)) begin
            state_r <= ST_EVAL;
          end else if (accept && (in_op == trpf_pkg::OP_REPORT)) begin
            state_r <= ST_REPORT;
          end
        end
        ST_EVAL: begin
          state_r <= ST_IDLE;
        end
        ST_REPORT: begin
          if (status.out_free && status.scan_last) begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- hdl/trpf_datapath.sv -----
// Datapath of the row predicate filter: match bitmap, comparator, report scan, output register.
`timescale 1ns / 1ps

module trpf_datapath #(
  parameter int ROW_COUNT = trpf_pkg::ROW_COUNT_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  trpf_pkg::dp_cmd_t              cmd,
  output trpf_pkg::dp_status_t           status,
  input  logic [trpf_pkg::ROW_W-1:0]     in_row,
  input  logic [trpf_pkg::VAL_W-1:0]     in_value,
  input  logic [trpf_pkg::VAL_W-1:0]     in_reference_value,
  input  logic [trpf_pkg::COND_W-1:0]    in_condition,
  input  logic [trpf_pkg::CONN_W-1:0]    in_connector,
  input  logic [trpf_pkg::BLOCK_W-1:0]   in_block,
  input  logic                           cfg_we,
  input  logic [trpf_pkg::VAL_W-1:0]     cfg_data,
  input  logic                           out_ready,
  output logic                           out_valid,
  output logic [trpf_pkg::ROW_W-1:0]     out_row_index,
  output logic                           out_found,
  output logic                           out_last
);

  localparam int RAW_WORDS = (ROW_COUNT + trpf_pkg::WORD_BITS - 1) / trpf_pkg::WORD_BITS;
  localparam int NUM_WORDS = (RAW_WORDS < trpf_pkg::MAX_WORDS) ? RAW_WORDS
                                                               : trpf_pkg::MAX_WORDS;
  localparam int RW = trpf_pkg::ROW_W;
  localparam int BW = trpf_pkg::BIT_W;

  // Match bitmap, one word per 64-row block
  logic [trpf_pkg::WORD_BITS-1:0] bits_r   [NUM_WORDS];
  logic [trpf_pkg::WORD_BITS-1:0] bits_nxt [NUM_WORDS];

  // Latched request
  logic [RW-1:0]                      row_r;
  logic signed [trpf_pkg::VAL_W-1:0]  val_r;
  logic signed [trpf_pkg::VAL_W-1:0]  ref_r;
  logic [trpf_pkg::COND_W-1:0]        cond_r;
  logic [trpf_pkg::CONN_W-1:0]        conn_r;
  logic [trpf_pkg::BLOCK_W-1:0]       blk_r;
  logic signed [trpf_pkg::VAL_W-1:0]  undef_r;

  // Report scan and output register
  logic [trpf_pkg::WORD_BITS-1:0] scan_r, scan_nxt, scan_rest;
  logic                           out_valid_r;
  logic [RW-1:0]                  out_row_r;
  logic                           out_found_r;
  logic                           out_last_r;

  logic [trpf_pkg::WORD_BITS-1:0] eval_word, rep_word;
  logic                           row_ok, old_bit, new_bit;
  logic                           cmp_eq, cmp_lt, cmp, res, ordered, cond_ok, conn_ok;
  logic                           undef_hit;
  logic [BW-1:0]                  pick;

  // Word selects for the evaluate and report paths
  always_comb begin
    eval_word = '0;
    rep_word  = '0;
    for (int i = 0; i < NUM_WORDS; i++) begin
      if (row_r[RW-1:BW] == trpf_pkg::BLOCK_W'(i)) eval_word = bits_r[i];
      if (in_block == trpf_pkg::BLOCK_W'(i))       rep_word  = bits_r[i];
    end
  end

  assign row_ok  = (32'(row_r) < ROW_COUNT);
  assign old_bit = eval_word[row_r[BW-1:0]];

  // Comparator
  assign cmp_eq    = (val_r == ref_r);
  assign cmp_lt    = (val_r < ref_r);
  assign undef_hit = (val_r == undef_r) || (ref_r == undef_r);

  always_comb begin
    cmp     = 1'b0;
    ordered = 1'b1;
    cond_ok = 1'b1;
    case (cond_r)
      trpf_pkg::COND_EQ:  begin cmp = cmp_eq;             ordered = 1'b0; end
      trpf_pkg::COND_NEQ: begin cmp = !cmp_eq;            ordered = 1'b0; end
      trpf_pkg::COND_LT:  cmp = cmp_lt;
      trpf_pkg::COND_LE:  cmp = cmp_lt || cmp_eq;
      trpf_pkg::COND_GE:  cmp = !cmp_lt;
      trpf_pkg::COND_GT:  cmp = !cmp_lt && !cmp_eq;
      default:            cond_ok = 1'b0;
    endcase
  end

  // Connector, then sentinel check on ordered compares
  always_comb begin
    res     = 1'b0;
    conn_ok = 1'b1;
    case (conn_r)
      trpf_pkg::CONN_NONE: res = cmp;
      trpf_pkg::CONN_OR:   res = old_bit || cmp;
      trpf_pkg::CONN_AND:  res = old_bit && cmp;
      default:             conn_ok = 1'b0;
    endcase
  end

  assign new_bit = cond_ok && conn_ok && res && !(ordered && undef_hit);

  // Bitmap next state
  always_comb begin
    for (int i = 0; i < NUM_WORDS; i++) begin
      bits_nxt[i] = bits_r[i];
      if (cmd.clear_all) begin
        bits_nxt[i] = '0;
      end else if (cmd.eval && row_ok && (row_r[RW-1:BW] == trpf_pkg::BLOCK_W'(i))) begin
        bits_nxt[i][row_r[BW-1:0]] = new_bit;
      end
    end
  end

  // Lowest set bit of the scan word
  always_comb begin
    pick = '0;
    for (int i = trpf_pkg::WORD_BITS - 1; i >= 0; i--) begin
      if (scan_r[i]) pick = BW'(i);
    end
  end

  assign scan_rest = scan_r & (scan_r - trpf_pkg::WORD_BITS'(1));

  always_comb begin
    scan_nxt = scan_r;
    if (cmd.load_scan) begin
      scan_nxt = rep_word;
    end else if (cmd.emit) begin
      scan_nxt = scan_rest;
    end
  end

  assign status.out_free  = !out_valid_r || out_ready;
  assign status.scan_last = (scan_rest == '0);

  // Control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_WORDS; i++) bits_r[i] <= '0;
      undef_r     <= trpf_pkg::UNDEF_RESET;
      out_valid_r <= 1'b0;
    end else begin
      for (int i = 0; i < NUM_WORDS; i++) bits_r[i] <= bits_nxt[i];
      if (cfg_we) undef_r <= cfg_data;
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      row_r  <= in_row;
      val_r  <= in_value;
      ref_r  <= in_reference_value;
      cond_r <= in_condition;
      conn_r <= in_connector;
      blk_r  <= in_block;
    end
    scan_r <= scan_nxt;
    if (cmd.emit) begin
      out_found_r <= |scan_r;
      out_last_r  <= (scan_rest == '0);
      out_row_r   <= (|scan_r) ? {blk_r, pick} : '0;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_row_index = out_row_r;
  assign out_found     = out_found_r;
  assign out_last      = out_last_r;

endmodule

// ----- hdl/table_row_predicate_filter.sv -----
// Top level of the row predicate filter: stream ports, controller and datapath.
//
//  channel  | direction | fields
//  ---------+-----------+-----------------------------------------------------------
//  in_      | slave     | tuser: operation; tdata: row, value, reference_value,
//           |           |   condition, connector, block
//  out_     | master    | tdata: row_index; tuser: found; tlast: last
//  cfg_     | slave     | tdata: undefined_code (always ready)
//
// Evaluate captures the request, then read-modify-writes the 64-bit match word.
// Clear zeroes every match bit on acceptance. A report gives N results (at least one),
// one per free output cycle, by the lowest-set-bit pick on the latched block word.
// Output stalls hold the report scan; the output register lets the next request in
// while the last result still waits. Reset clears all match bits at once and sets
// the sentinel to -2^47; no clearing pass follows reset.
`timescale 1ns / 1ps

module table_row_predicate_filter #(
  parameter int ROW_COUNT = trpf_pkg::ROW_COUNT_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // [9:0] row, [57:10] value, [105:58] reference_value, [108:106] condition,
  // [110:109] connector, [114:111] block, [119:115] zero
  input  logic [trpf_pkg::IN_TDATA_W-1:0]     in_tdata,
  // [1:0] operation
  input  logic [trpf_pkg::OP_W-1:0]           in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [9:0] row_index, [15:10] zero
  output logic [trpf_pkg::OUT_TDATA_W-1:0]    out_tdata,
  // [0] found
  output logic [0:0]                          out_tuser,
  output logic                                out_tlast,
  input  logic                                cfg_tvalid,
  output logic                                cfg_tready,
  // [47:0] undefined_code
  input  logic [trpf_pkg::CFG_TDATA_W-1:0]    cfg_tdata
);

  `include "assert_macros.svh"

  trpf_pkg::dp_cmd_t    cmd;
  trpf_pkg::dp_status_t status;
  logic [trpf_pkg::ROW_W-1:0] out_row;
  logic                       out_found;

  assign cfg_tready = 1'b1;

  trpf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_op    (in_tuser),
    .status   (status),
    .in_ready (in_tready),
    .cmd      (cmd)
  );

  trpf_datapath #(
    .ROW_COUNT (ROW_COUNT)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .status             (status),
    .in_row             (in_tdata[9:0]),
    .in_value           (in_tdata[57:10]),
    .in_reference_value (in_tdata[105:58]),
    .in_condition       (in_tdata[108:106]),
    .in_connector       (in_tdata[110:109]),
    .in_block           (in_tdata[114:111]),
    .cfg_we             (cfg_tvalid && cfg_tready),
    .cfg_data           (cfg_tdata),
    .out_ready          (out_tready),
    .out_valid          (out_tvalid),
    .out_row_index      (out_row),
    .out_found          (out_found),
    .out_last           (out_tlast)
  );

  assign out_tdata = {(trpf_pkg::OUT_TDATA_W - trpf_pkg::ROW_W)'(0), out_row};
  assign out_tuser = out_found;

  // A report or evaluate request keeps the input closed after it is taken
  `TRPF_ASSERT_NEXT(a_report_blocks, in_tvalid && in_tready && (in_tuser == trpf_pkg::OP_REPORT), !in_tready)
  `TRPF_ASSERT_NEXT(a_eval_blocks, in_tvalid && in_tready && (in_tuser == trpf_pkg::OP_EVAL), !in_tready)
  // A result is never pushed over one still waiting
  `TRPF_ASSERT_NOW(a_emit_free, cmd.emit, !out_tvalid || out_tready)
  // An empty report gives a single closing result with row zero
  `TRPF_ASSERT_NOW(a_empty_last, out_tvalid && !out_tuser[0], out_tlast && (out_tdata == '0))

endmodule

// ----- bench/tb_table_row_predicate_filter.sv -----
// Self-checking testbench for the row predicate filter: match bitmap, reports, sentinel.
`timescale 1ns / 1ps

module tb_table_row_predicate_filter;
  import trpf_pkg::*;

  // Codes the package leaves unnamed: they must be ignored or give false
  localparam logic [OP_W-1:0]   OP_UNUSED = 2'd3;
  localparam logic [COND_W-1:0] COND_UNKNOWN_A = 3'd6;
  localparam logic [COND_W-1:0] COND_UNKNOWN_B = 3'd7;
  localparam logic [CONN_W-1:0] CONN_UNKNOWN = 2'd3;

  localparam logic [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

  localparam int QUIET_LIMIT = 400;  // cycles with no handshake anywhere
  localparam int SETTLE_CYCLES = 8;  // evaluate still in flight after the last result

  // Receiver stall modes
  localparam int RX_FREE = 0;
  localparam int RX_RANDOM = 1;
  localparam int RX_BURSTS = 2;

  typedef struct {
    logic [OP_W-1:0]    op;
    logic [ROW_W-1:0]   row;
    logic [VAL_W-1:0]   val;
    logic [VAL_W-1:0]   refv;
    logic [COND_W-1:0]  cond;
    logic [CONN_W-1:0]  conn;
    logic [BLOCK_W-1:0] blk;
  } request_t;

  typedef struct {
    logic [ROW_W-1:0] row_index;
    logic             found;
    logic             last;
  } hit_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [IN_TDATA_W-1:0] in_tdata;
  logic [OP_W-1:0] in_tuser;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [0:0] out_tuser;
  logic out_tlast;
  logic cfg_tvalid;
  logic cfg_tready;
  logic [CFG_TDATA_W-1:0] cfg_tdata;

  // Predictor state
  logic [WORD_BITS-1:0] sel_bits [MAX_WORDS];
  logic [VAL_W-1:0] undef_code;
  hit_t expected_hits [$];

  int fail_count = 0;
  int n_requests = 0;
  int n_reports = 0;
  int n_clears = 0;
  int n_hits = 0;
  int n_sentinels = 0;
  int burst_left = 0;
  bit sender_calm = 1'b0;

  int quiet_cycles = 0;
  int rx_cycle = 0;
  int rx_mode = RX_FREE;
  int rx_hold = 0;

  table_row_predicate_filter u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_tvalid (cfg_tvalid),
    .cfg_tready (cfg_tready),
    .cfg_tdata  (cfg_tdata)
  );

  always #5 clk = ~clk;

  // New match bit for one evaluate; sentinel check comes after combining
  function automatic logic next_match(logic old, request_t r);
    logic cmp;
    logic ordered;
    logic res;
    ordered = 1'b1;
    case (r.cond)
      COND_EQ: begin
        cmp = (r.val == r.refv);
        ordered = 1'b0;
      end
      COND_NEQ: begin
        cmp = (r.val != r.refv);
        ordered = 1'b0;
      end
      COND_LT: cmp = ($signed(r.val) < $signed(r.refv));
      COND_LE: cmp = ($signed(r.val) <= $signed(r.refv));
      COND_GE: cmp = ($signed(r.val) >= $signed(r.refv));
      COND_GT: cmp = ($signed(r.val) > $signed(r.refv));
      default: return 1'b0;
    endcase
    case (r.conn)
      CONN_NONE: res = cmp;
      CONN_OR:   res = old | cmp;
      CONN_AND:  res = old & cmp;
      default:   return 1'b0;
    endcase
    if (ordered)
      res = res && (r.val != undef_code) && (r.refv != undef_code);
    return res;
  endfunction

  // Update the bitmap and queue the results a request will produce
  task automatic track_request(input request_t r);
    logic [WORD_BITS-1:0] word;
    logic old;
    hit_t h;
    case (r.op)
      OP_EVAL: begin
        old = sel_bits[r.row[ROW_W-1:BIT_W]][r.row[BIT_W-1:0]];
        sel_bits[r.row[ROW_W-1:BIT_W]][r.row[BIT_W-1:0]] = next_match(old, r);
      end
      OP_CLEAR: begin
        n_clears++;
        foreach (sel_bits[w]) sel_bits[w] = '0;
      end
      OP_REPORT: begin
        n_reports++;
        word = sel_bits[r.blk];
        if (word == '0) begin
          h.row_index = '0;
          h.found = 1'b0;
          h.last = 1'b1;
          expected_hits.insert(expected_hits.size(), h);
        end else begin
          for (int i = 0; i < WORD_BITS; i++) begin
            if (word[i]) begin
              h.row_index = {r.blk, BIT_W'(i)};
              h.found = 1'b1;
              h.last = ((word >> (i + 1)) == '0);
              expected_hits.insert(expected_hits.size(), h);
            end
          end
        end
      end
      default: ;  // unused code: nothing happens
    endcase
  endtask

  // Drive one request with burst/gap idling, wait for its handshake
  task automatic send_request(input request_t r);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = (sender_calm || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        @(negedge clk);
        in_tvalid = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_tuser = r.op;
    in_tdata = {5'b0, r.blk, r.conn, r.cond, r.refv, r.val, r.row};
    in_tvalid = 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    n_requests++;
    track_request(r);
  endtask

  // Stop sending and wait until every expected result has come back
  task automatic hold_until_drained();
    @(negedge clk);
    in_tvalid = 1'b0;
    burst_left = 0;
    while (expected_hits.size() != 0) @(posedge clk);
  endtask

  task automatic write_undefined_code(input logic [VAL_W-1:0] code);
    hold_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_tdata = code;
    cfg_tvalid = 1'b1;
    @(posedge clk);
    while (!cfg_tready) @(posedge clk);
    undef_code = code;
    n_sentinels++;
    @(negedge clk);
    cfg_tvalid = 1'b0;
  endtask

  function automatic logic [VAL_W-1:0] rand48();
    return VAL_W'({$urandom, $urandom});
  endfunction

  // Column values biased towards extremes, the sentinel and near-equal values
  function automatic logic [VAL_W-1:0] pick_value();
    int v;
    case ($urandom_range(0, 9))
      0: return VAL_MAX;
      1: return VAL_MIN;
      2: return undef_code;
      3, 4: begin
        v = $urandom_range(0, 6) - 3;
        return {{(VAL_W-32){v[31]}}, v};
      end
      5: return ($urandom_range(0, 1) == 0) ? undef_code + 1'b1 : undef_code - 1'b1;
      default: return rand48();
    endcase
  endfunction

  function automatic request_t make_eval(logic [ROW_W-1:0] row, logic [VAL_W-1:0] val,
                                         logic [VAL_W-1:0] refv, logic [COND_W-1:0] cond,
                                         logic [CONN_W-1:0] conn);
    request_t r;
    r.op = OP_EVAL;
    r.row = row;
    r.val = val;
    r.refv = refv;
    r.cond = cond;
    r.conn = conn;
    r.blk = BLOCK_W'($urandom);
    return r;
  endfunction

  // Report, clear or unused code; the other fields carry noise
  function automatic request_t make_cmd(logic [OP_W-1:0] op, logic [BLOCK_W-1:0] blk);
    request_t r;
    r.op = op;
    r.row = ROW_W'($urandom);
    r.val = rand48();
    r.refv = rand48();
    r.cond = COND_W'($urandom);
    r.conn = CONN_W'($urandom);
    r.blk = blk;
    return r;
  endfunction

  // Each condition and connector, the sentinel after combining, unknown codes
  task automatic test_directed_cases();
    send_request(make_cmd(OP_REPORT, 4'd0));
    send_request(make_eval(10'd0, 48'd5, 48'd5, COND_EQ, CONN_NONE));
    send_request(make_eval(10'd1, VAL_MAX, VAL_MIN, COND_NEQ, CONN_NONE));
    send_request(make_eval(10'd2, VAL_MIN + 1'b1, VAL_MAX, COND_LT, CONN_NONE));
    send_request(make_eval(10'd3, VAL_MAX, VAL_MAX, COND_LE, CONN_NONE));
    send_request(make_eval(10'd4, '1, -48'sd2, COND_GE, CONN_NONE));
    send_request(make_eval(10'd5, VAL_MAX, VAL_MIN, COND_GT, CONN_NONE));
    send_request(make_eval(10'd6, 48'd0, '1, COND_GT, CONN_NONE));
    send_request(make_eval(10'd63, VAL_MIN, VAL_MIN, COND_EQ, CONN_NONE));
    send_request(make_eval(10'd0, 48'd1, 48'd0, COND_LT, CONN_OR));
    send_request(make_eval(10'd1, VAL_MIN, 48'd0, COND_GE, CONN_AND));
    // set bit survives OR, then the sentinel clears it anyway
    send_request(make_eval(10'd3, VAL_MIN, 48'd0, COND_LE, CONN_OR));
    send_request(make_eval(10'd4, 48'd7, 48'd7, COND_UNKNOWN_A, CONN_NONE));
    send_request(make_eval(10'd6, 48'd7, 48'd7, COND_EQ, CONN_UNKNOWN));
    send_request(make_eval(10'd62, 48'd7, 48'd7, COND_UNKNOWN_B, CONN_OR));
    send_request(make_cmd(OP_REPORT, 4'd0));
    send_request(make_eval(10'd1023, VAL_MAX, VAL_MAX, COND_GE, CONN_NONE));
    send_request(make_eval(10'd960, 48'd0, 48'd0, COND_EQ, CONN_NONE));
    send_request(make_cmd(OP_REPORT, 4'd15));
    send_request(make_cmd(OP_UNUSED, 4'd15));
    send_request(make_cmd(OP_REPORT, 4'd7));
    send_request(make_cmd(OP_CLEAR, 4'd0));
    send_request(make_cmd(OP_REPORT, 4'd15));
    send_request(make_cmd(OP_REPORT, 4'd0));
  endtask

  // Set every row of one block, then list all 64 of them
  task automatic test_full_block(input logic [BLOCK_W-1:0] blk);
    logic [VAL_W-1:0] v;
    for (int i = 0; i < WORD_BITS; i++) begin
      v = pick_value();
      send_request(make_eval({blk, BIT_W'(i)}, v, v, COND_EQ, CONN_NONE));
    end
    send_request(make_cmd(OP_REPORT, blk));
  endtask

  // Random traffic under one sentinel setting, mostly around a hot block that changes halfway
  task automatic test_sentinel_phase(input logic [VAL_W-1:0] code, input int count);
    logic [BLOCK_W-1:0] hot;
    logic [ROW_W-1:0] row;
    logic [VAL_W-1:0] v;
    logic [COND_W-1:0] cond;
    logic [CONN_W-1:0] conn;
    int pick;
    int sent;
    write_undefined_code(code);
    hot = BLOCK_W'($urandom);
    sent = 0;
    while (sent < count) begin
      if (sent == count / 2) begin
        hold_until_drained();
        hot = BLOCK_W'($urandom);
      end
      pick = $urandom_range(0, 99);
      if (pick < 60 || pick >= 90) begin
        row = (pick >= 90) ? ROW_W'($urandom) :
              {($urandom_range(0, 3) == 0) ? BLOCK_W'($urandom) : hot,
               BIT_W'($urandom)};
        v = pick_value();
        cond = ($urandom_range(0, 11) == 0) ? COND_W'($urandom_range(6, 7))
                                             : COND_W'($urandom_range(0, 5));
        conn = ($urandom_range(0, 19) == 0) ? CONN_UNKNOWN : CONN_W'($urandom_range(0, 2));
        send_request(make_eval(row, v, ($urandom_range(0, 3) == 0) ? v : pick_value(),
                               cond, conn));
        sent++;
      end else if (pick < 82) begin
        send_request(make_cmd(OP_REPORT,
                              ($urandom_range(0, 9) < 7) ? hot : BLOCK_W'($urandom)));
        sent++;
      end else if (pick < 85) begin
        send_request(make_cmd(OP_CLEAR, BLOCK_W'($urandom)));
        sent++;
      end else begin
        send_request(make_cmd(OP_UNUSED, BLOCK_W'($urandom)));
      end
    end
  endtask

  // Receiver: free-running, random, or long stall bursts, in modes picked at random
  always @(negedge clk) begin
    rx_cycle <= rx_cycle + 1;
    if (rx_cycle % 128 == 0) rx_mode <= $urandom_range(RX_FREE, RX_BURSTS);
    case (rx_mode)
      RX_FREE: out_tready <= 1'b1;
      RX_RANDOM: out_tready <= ($urandom_range(0, 3) != 0);
      default: begin
        if (rx_hold == 0) begin
          out_tready <= !out_tready;
          rx_hold <= out_tready ? $urandom_range(1, 24) : $urandom_range(1, 8);
        end else begin
          rx_hold <= rx_hold - 1;
        end
      end
    endcase
  end

  // Result checker
  always @(posedge clk) begin
    hit_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_hits.size() == 0) begin
        fail_count++;
        $error("result with none expected: row_index %0d found %0b last %0b",
               out_tdata[ROW_W-1:0], out_tuser[0], out_tlast);
      end else begin
        want = expected_hits.pop_front();
        n_hits++;
        if (out_tdata[ROW_W-1:0] !== want.row_index) begin
          fail_count++;
          $error("row_index mismatch: expected %0d, got %0d",
                 want.row_index, out_tdata[ROW_W-1:0]);
        end
        if (out_tuser[0] !== want.found) begin
          fail_count++;
          $error("found mismatch: expected %0b, got %0b", want.found, out_tuser[0]);
        end
        if (out_tlast !== want.last) begin
          fail_count++;
          $error("last mismatch: expected %0b, got %0b", want.last, out_tlast);
        end
      end
    end
  end

  // Watchdog on cycles without any handshake
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_tvalid && cfg_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("[table_row_predicate_filter] ERROR");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    cfg_tvalid = 1'b0;
    cfg_tdata = '0;
    undef_code = UNDEF_RESET;
    foreach (sel_bits[w]) sel_bits[w] = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed_cases();
    test_sentinel_phase(VAL_MAX, 56);
    test_full_block(BLOCK_W'($urandom));
    sender_calm = 1'b1;
    test_sentinel_phase(48'd0, 56);
    sender_calm = 1'b0;
    test_sentinel_phase(rand48(), 56);
    test_sentinel_phase(VAL_MIN, 56);
    test_sentinel_phase(48'd1, 56);

    hold_until_drained();
    repeat (20) @(posedge clk);
    if (expected_hits.size() != 0) begin
      fail_count++;
      $error("%0d expected results never arrived", expected_hits.size());
    end
    $display("Sent %0d requests (%0d reports, %0d clears) under %0d sentinel settings;",
             n_requests, n_reports, n_clears, n_sentinels);
    $display("checked %0d report results with random sender gaps and receiver stalls.",
             n_hits);
    if (fail_count == 0) begin
      $display("[table_row_predicate_filter] OK");
    end else begin
      $display("[table_row_predicate_filter] ERROR");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+hdl
hdl/trpf_pkg.sv
hdl/trpf_ctrl.sv
hdl/trpf_datapath.sv
hdl/table_row_predicate_filter.sv
bench/tb_table_row_predicate_filter.sv
